/* sv/pnpl_pkg.sv */
// shared types and constants for the periodic nearest point lookup unit
package pnpl_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int POS_W       = 24;
  localparam int DIFF_W      = POS_W + 1;
  localparam int WRAP_W      = POS_W + 2;
  localparam int MAG_W       = POS_W + 1;
  localparam int SQ_W        = 2 * POS_W + 1;
  localparam int CURV_W      = 32;
  localparam int LEN_W       = 23;
  localparam int DIST_W      = 50;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 23;
  localparam int DRAIN_CYCLES = 4;
  localparam int DRAIN_W     = $clog2(DRAIN_CYCLES);

  localparam logic [DIST_W-1:0]  START_DIST  = DIST_W'(20000) << 32;
  localparam logic [DIST_W-1:0]  FAR_DIST    = DIST_W'(4) << 32;
  localparam logic [LEN_W-1:0]   BOX_RESET   = LEN_W'(655360);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_ENTRIES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_X       = 2'd0,
    REG_BOX_Y       = 2'd1,
    REG_BOX_Z       = 2'd2,
    REG_ENTRY_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } command_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_REPLY = 5'b10000
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]   box_x;
    logic [LEN_W-1:0]   box_y;
    logic [LEN_W-1:0]   box_z;
    logic [COUNT_W-1:0] entry_count;
  } cfg_t;

  typedef struct packed {
    logic              load_wr;
    logic              query_init;
    logic              issue;
    logic [ADDR_W-1:0] issue_addr;
    logic              fetch;
  } dp_cmd_t;

endpackage

/* sv/pnpl_cfg.sv */
// configuration register file
module pnpl_cfg
  import pnpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_x       <= BOX_RESET;
      cfg.box_y       <= BOX_RESET;
      cfg.box_z       <= BOX_RESET;
      cfg.entry_count <= COUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOX_X:       cfg.box_x       <= cfg_data[LEN_W-1:0];
        REG_BOX_Y:       cfg.box_y       <= cfg_data[LEN_W-1:0];
        REG_BOX_Z:       cfg.box_z       <= cfg_data[LEN_W-1:0];
        REG_ENTRY_COUNT: cfg.entry_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/pnpl_ctrl.sv */
// scan sequencer state machine
module pnpl_ctrl
  import pnpl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               command,
  input  logic [COUNT_W-1:0] entry_count,
  output logic               busy,
  output logic               result_valid,
  output dp_cmd_t            dp_cmd
);

  state_t             state, state_next;
  logic [COUNT_W-1:0] scan_cnt, scan_cnt_next;
  logic [COUNT_W-1:0] scan_len;
  logic [DRAIN_W-1:0] drain_cnt, drain_cnt_next;
  logic               accept;

  // saturate the scan at the table size
  assign scan_len = (entry_count > COUNT_MAX) ? COUNT_MAX : entry_count;
  assign accept   = start && (state == ST_IDLE);

  always_comb begin
    state_next          = state;
    scan_cnt_next       = scan_cnt;
    drain_cnt_next      = drain_cnt;
    dp_cmd.load_wr      = 1'b0;
    dp_cmd.query_init   = 1'b0;
    dp_cmd.issue        = 1'b0;
    dp_cmd.issue_addr   = scan_cnt[ADDR_W-1:0];
    dp_cmd.fetch        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        scan_cnt_next  = '0;
        drain_cnt_next = '0;
        if (accept) begin
          if (command_t'(command) == CMD_LOAD) begin
            dp_cmd.load_wr = 1'b1;
          end else begin
            dp_cmd.query_init = 1'b1;
            state_next = (scan_len == '0) ? ST_FETCH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        dp_cmd.issue  = 1'b1;
        scan_cnt_next = scan_cnt + COUNT_W'(1);
        if (scan_cnt_next == scan_len) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_cnt_next = drain_cnt + DRAIN_W'(1);
        if (drain_cnt == DRAIN_W'(DRAIN_CYCLES - 1)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        dp_cmd.fetch = 1'b1;
        state_next   = ST_REPLY;
      end
      ST_REPLY: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_cnt  <= '0;
      drain_cnt <= '0;
    end else begin
      state     <= state_next;
      scan_cnt  <= scan_cnt_next;
      drain_cnt <= drain_cnt_next;
    end
  end

  assign busy         = (state != ST_IDLE);
  assign result_valid = (state == ST_REPLY);

endmodule

/* sv/pnpl_datapath.sv */
// reference table, distance pipeline and running minimum
module pnpl_datapath
  import pnpl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  dp_cmd,
  input  cfg_t                     cfg,
  input  logic [ADDR_W-1:0]        entry_index,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  logic signed [CURV_W-1:0] mean_curvature_in,
  input  logic signed [CURV_W-1:0] gauss_curvature_in,
  output logic [ADDR_W-1:0]        nearest_index,
  output logic signed [CURV_W-1:0] mean_curvature_out,
  output logic signed [CURV_W-1:0] gauss_curvature_out,
  output logic [DIST_W-1:0]        best_distance_sq,
  output logic                     too_far
);

  // positions and curvatures kept in separate memories
  logic [3*POS_W-1:0]  pos_mem  [MAX_ENTRIES];
  logic [2*CURV_W-1:0] curv_mem [MAX_ENTRIES];

  logic signed [POS_W-1:0] q_x, q_y, q_z;

  logic [3*POS_W-1:0] rd_pos;
  logic [ADDR_W-1:0]  idx_a, idx_b, idx_c, idx_d;
  logic               vld_a, vld_b, vld_c, vld_d;
  logic [MAG_W-1:0]   mag_x, mag_y, mag_z;
  logic [SQ_W-1:0]    sq_x, sq_y, sq_z;
  logic [DIST_W-1:0]  sum_d;
  logic [DIST_W-1:0]  best;
  logic [ADDR_W-1:0]  best_idx;
  logic [2*CURV_W-1:0] curv_q;

  function automatic logic [MAG_W-1:0] wrap_mag(
    input logic signed [POS_W-1:0] q,
    input logic signed [POS_W-1:0] r,
    input logic [LEN_W-1:0]         len
  );
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        m;
    logic signed [WRAP_W-1:0] w;
    logic [WRAP_W-1:0]        wm;
    d = DIFF_W'(q) - DIFF_W'(r);
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    w = WRAP_W'(d);
    // minimum image: fold once by the box length
    if ({m, 1'b0} > {{(DIFF_W+1-LEN_W){1'b0}}, len}) begin
      if (d < 0) begin
        w = w + $signed({3'b000, len});
      end else if (d > 0) begin
        w = w - $signed({3'b000, len});
      end
    end
    wm = w[WRAP_W-1] ? WRAP_W'(-w) : WRAP_W'(w);
    return wm[MAG_W-1:0];
  endfunction

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (dp_cmd.load_wr) begin
      pos_mem[entry_index]  <= {pos_x, pos_y, pos_z};
      curv_mem[entry_index] <= {mean_curvature_in, gauss_curvature_in};
    end
    if (dp_cmd.issue) begin
      rd_pos <= pos_mem[dp_cmd.issue_addr];
    end
    if (dp_cmd.fetch) begin
      curv_q <= curv_mem[best_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
    end else begin
      vld_a <= dp_cmd.issue;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_d <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.query_init) begin
      q_x <= pos_x;
      q_y <= pos_y;
      q_z <= pos_z;
    end
    idx_a <= dp_cmd.issue_addr;
    idx_b <= idx_a;
    idx_c <= idx_b;
    idx_d <= idx_c;
    mag_x <= wrap_mag(q_x, rd_pos[3*POS_W-1:2*POS_W], cfg.box_x);
    mag_y <= wrap_mag(q_y, rd_pos[2*POS_W-1:POS_W],   cfg.box_y);
    mag_z <= wrap_mag(q_z, rd_pos[POS_W-1:0],         cfg.box_z);
    sq_x  <= SQ_W'(mag_x * mag_x);
    sq_y  <= SQ_W'(mag_y * mag_y);
    sq_z  <= SQ_W'(mag_z * mag_z);
    sum_d <= DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);
  end

  // running minimum, first strict minimum wins
  always_ff @(posedge clk) begin
    if (dp_cmd.query_init) begin
      best     <= START_DIST;
      best_idx <= '0;
    end else if (vld_d && (sum_d < best)) begin
      best     <= sum_d;
      best_idx <= idx_d;
    end
    if (dp_cmd.fetch) begin
      too_far <= (best > FAR_DIST);
    end
  end

  assign nearest_index       = best_idx;
  assign best_distance_sq    = best;
  assign mean_curvature_out  = curv_q[2*CURV_W-1:CURV_W];
  assign gauss_curvature_out = curv_q[CURV_W-1:0];

endmodule

/* sv/periodic_nearest_point_lookup_unit.sv */
// top level of the periodic nearest point lookup unit
// A load beat (command 0) writes one table slot in the cycle it is accepted and
// gives no result; busy stays low, so the next beat can follow at once. A query
// beat (command 1) scans slots 0 to min(entry_count, 1024)-1, one slot a cycle
// through a single table read port; after the last issue the sequencer drains the
// distance pipeline, reads the curvatures of the best slot and then raises the
// result; with an entry count of zero there is nothing to issue or drain, so it
// goes straight to the curvature read and the result. busy is high from the cycle
// after acceptance through the result cycle, so the next beat can be taken in the
// cycle after the result.
// The result stands on the ports for the single cycle that result_valid is
// high and the receiver must take it then: there is no back-pressure. The
// table is not cleared after reset; a query must only reach slots already
// loaded. Configuration is accepted at any time (cfg_ready is tied high), but
// should only be written while busy is low.
module periodic_nearest_point_lookup_unit
  import pnpl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     command,
  input  logic [ADDR_W-1:0]        entry_index,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  logic signed [CURV_W-1:0] mean_curvature_in,
  input  logic signed [CURV_W-1:0] gauss_curvature_in,
  // result channel, one cycle strobe
  output logic                     result_valid,
  output logic [ADDR_W-1:0]        nearest_index,
  output logic signed [CURV_W-1:0] mean_curvature_out,
  output logic signed [CURV_W-1:0] gauss_curvature_out,
  output logic [DIST_W-1:0]        best_distance_sq,
  output logic                     too_far,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t    cfg;
  dp_cmd_t dp_cmd;

  // register writes are never held off
  assign cfg_ready = 1'b1;

  pnpl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: load writes, query scan, drain, curvature fetch, result beat
  pnpl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .entry_count  (cfg.entry_count),
    .busy         (busy),
    .result_valid (result_valid),
    .dp_cmd       (dp_cmd)
  );

  // table memories, minimum-image distance pipeline, running minimum
  pnpl_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .dp_cmd              (dp_cmd),
    .cfg                 (cfg),
    .entry_index         (entry_index),
    .pos_x               (pos_x),
    .pos_y               (pos_y),
    .pos_z               (pos_z),
    .mean_curvature_in   (mean_curvature_in),
    .gauss_curvature_in  (gauss_curvature_in),
    .nearest_index       (nearest_index),
    .mean_curvature_out  (mean_curvature_out),
    .gauss_curvature_out (gauss_curvature_out),
    .best_distance_sq    (best_distance_sq),
    .too_far             (too_far)
  );

endmodule

/* bench/tb_periodic_nearest_point_lookup_unit.sv */
`timescale 1ns / 100ps
// self-checking testbench for the periodic nearest point lookup unit
module tb_periodic_nearest_point_lookup_unit;
  import pnpl_pkg::*;

  // the slowest correct run stays well under this limit: a few hundred table loads,
  // a few dozen long scans of at most LONG_SLOTS slots, and a few hundred
  // beats on short tables
  localparam int CYCLE_LIMIT   = 1_000_000;
  // a load leaves nothing to wait for, so let the pipeline drain and settle
  localparam int SETTLE_CYCLES = DRAIN_CYCLES + 8;
  localparam int MAX_REPORTS   = 40;
  // slots loaded by the long table test
  localparam int LONG_SLOTS    = 320;

  // one command beat as the sender sees it
  typedef struct {
    command_t                  cmd;
    logic [ADDR_W-1:0]         slot;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic signed [POS_W-1:0]   z;
    logic signed [CURV_W-1:0]  mean;
    logic signed [CURV_W-1:0]  gauss;
  } beat_t;

  // what a query should come back with
  typedef struct {
    logic [ADDR_W-1:0]         index;
    logic signed [CURV_W-1:0]  mean;
    logic signed [CURV_W-1:0]  gauss;
    logic [DIST_W-1:0]         dist_sq;
    logic                      far;
  } nearest_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     command = CMD_LOAD;
  logic [ADDR_W-1:0]        entry_index = '0;
  logic signed [POS_W-1:0]  pos_x = '0;
  logic signed [POS_W-1:0]  pos_y = '0;
  logic signed [POS_W-1:0]  pos_z = '0;
  logic signed [CURV_W-1:0] mean_curvature_in = '0;
  logic signed [CURV_W-1:0] gauss_curvature_in = '0;
  logic                     result_valid;
  logic [ADDR_W-1:0]        nearest_index;
  logic signed [CURV_W-1:0] mean_curvature_out;
  logic signed [CURV_W-1:0] gauss_curvature_out;
  logic [DIST_W-1:0]        best_distance_sq;
  logic                     too_far;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // shadow copy of the lookup table and the register file
  logic signed [POS_W-1:0]  slot_x [MAX_ENTRIES];
  logic signed [POS_W-1:0]  slot_y [MAX_ENTRIES];
  logic signed [POS_W-1:0]  slot_z [MAX_ENTRIES];
  logic signed [CURV_W-1:0] slot_mean [MAX_ENTRIES];
  logic signed [CURV_W-1:0] slot_gauss [MAX_ENTRIES];
  bit                       slot_loaded [MAX_ENTRIES];
  logic [LEN_W-1:0]         box_x = BOX_RESET;
  logic [LEN_W-1:0]         box_y = BOX_RESET;
  logic [LEN_W-1:0]         box_z = BOX_RESET;
  logic [COUNT_W-1:0]       scan_count = COUNT_RESET;

  // queries accepted whose result has not shown up yet, oldest first
  nearest_t awaited_nearest [$];

  int cycle_count = 0;
  int err_count = 0;
  int burst_left = 0;
  bit gappy = 1'b0;

  always #2 clk = ~clk;

  periodic_nearest_point_lookup_unit DUT (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .command             (command),
    .entry_index         (entry_index),
    .pos_x               (pos_x),
    .pos_y               (pos_y),
    .pos_z               (pos_z),
    .mean_curvature_in   (mean_curvature_in),
    .gauss_curvature_in  (gauss_curvature_in),
    .result_valid        (result_valid),
    .nearest_index       (nearest_index),
    .mean_curvature_out  (mean_curvature_out),
    .gauss_curvature_out (gauss_curvature_out),
    .best_distance_sq    (best_distance_sq),
    .too_far             (too_far),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // squared offset along one axis under the minimum-image rule: wrap once
  // only when the offset is strictly more than half the box
  function automatic longint unsigned axis_dist_sq(input logic signed [POS_W-1:0] q,
                                                   input logic signed [POS_W-1:0] r,
                                                   input logic [LEN_W-1:0] len);
    longint d;
    longint mag;
    d = longint'(q) - longint'(r);
    mag = (d < 0) ? -d : d;
    if (2 * mag > longint'(len)) begin
      if (d < 0) d = d + longint'(len);
      else if (d > 0) d = d - longint'(len);
    end
    mag = (d < 0) ? -d : d;
    return mag * mag;
  endfunction

  // linear scan from slot 0; a slot takes over only when strictly closer,
  // so ties keep the lower index and nothing at or beyond the start wins
  function automatic nearest_t find_nearest(input logic signed [POS_W-1:0] qx,
                                            input logic signed [POS_W-1:0] qy,
                                            input logic signed [POS_W-1:0] qz);
    nearest_t         res;
    longint unsigned  best;
    longint unsigned  d2;
    int               n;
    int               best_slot;
    n = (scan_count > COUNT_MAX) ? MAX_ENTRIES : int'(scan_count);
    best = START_DIST;
    best_slot = 0;
    for (int i = 0; i < n; i++) begin
      d2 = axis_dist_sq(qx, slot_x[i], box_x) + axis_dist_sq(qy, slot_y[i], box_y)
         + axis_dist_sq(qz, slot_z[i], box_z);
      if (d2 < best) begin
        best = d2;
        best_slot = i;
      end
    end
    res.index   = ADDR_W'(best_slot);
    res.mean    = slot_mean[best_slot];
    res.gauss   = slot_gauss[best_slot];
    res.dist_sq = DIST_W'(best);
    res.far     = (best > FAR_DIST);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    if (err_count < MAX_REPORTS)
      $display("mismatch on %s at %0t: got %0h, want %0h", field, $time, got, want);
    err_count++;
  endtask

  // results cannot be held off, so every strobe is taken at the edge ending it
  always @(posedge clk) begin : result_check
    nearest_t want;
    if (!rst && result_valid) begin
      if (awaited_nearest.size() == 0) begin
        report_mismatch("unexpected result", nearest_index, 0);
      end else begin
        want = awaited_nearest.pop_front();
        if (nearest_index !== want.index)
          report_mismatch("nearest_index", nearest_index, want.index);
        if (mean_curvature_out !== want.mean)
          report_mismatch("mean_curvature_out", mean_curvature_out, want.mean);
        if (gauss_curvature_out !== want.gauss)
          report_mismatch("gauss_curvature_out", gauss_curvature_out, want.gauss);
        if (best_distance_sq !== want.dist_sq)
          report_mismatch("best_distance_sq", best_distance_sq, want.dist_sq);
        if (too_far !== want.far)
          report_mismatch("too_far", too_far, want.far);
      end
    end
  end

  // hard stop if the block hangs or drops a result
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // start stays high after acceptance, the caller decides whether to drop it
  task automatic send_beat(input beat_t b);
    start              <= 1'b1;
    command            <= b.cmd;
    entry_index        <= b.slot;
    pos_x              <= b.x;
    pos_y              <= b.y;
    pos_z              <= b.z;
    mean_curvature_in  <= b.mean;
    gauss_curvature_in <= b.gauss;
    do @(posedge clk); while (busy);
    // beat taken at this edge
    if (b.cmd == CMD_LOAD) begin
      slot_x[b.slot]      = b.x;
      slot_y[b.slot]      = b.y;
      slot_z[b.slot]      = b.z;
      slot_mean[b.slot]   = b.mean;
      slot_gauss[b.slot]  = b.gauss;
      slot_loaded[b.slot] = 1'b1;
    end else begin
      awaited_nearest = {awaited_nearest, find_nearest(b.x, b.y, b.z)};
    end
  endtask

  // bursts of random length with random gaps, when the current test wants gaps
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (gappy) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // all results in and the pipeline quiet
  task automatic wait_idle();
    start <= 1'b0;
    while (awaited_nearest.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // valid is left high so back to back writes need no second assignment
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      REG_BOX_X:       box_x = v[LEN_W-1:0];
      REG_BOX_Y:       box_y = v[LEN_W-1:0];
      REG_BOX_Z:       box_z = v[LEN_W-1:0];
      REG_ENTRY_COUNT: scan_count = v[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [LEN_W-1:0] lx, input logic [LEN_W-1:0] ly,
                            input logic [LEN_W-1:0] lz, input logic [CFG_DATA_W-1:0] count);
    wait_idle();
    write_reg(REG_BOX_X, lx);
    write_reg(REG_BOX_Y, ly);
    write_reg(REG_BOX_Z, lz);
    write_reg(REG_ENTRY_COUNT, count);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic beat_t mk_beat(input command_t c, input int slot, input int x,
                                    input int y, input int z, input int mean, input int gauss);
    beat_t b;
    b.cmd   = c;
    b.slot  = ADDR_W'(slot);
    b.x     = POS_W'(x);
    b.y     = POS_W'(y);
    b.z     = POS_W'(z);
    b.mean  = mean;
    b.gauss = gauss;
    return b;
  endfunction

  // random offset around a point, sometimes shifted by one whole box
  function automatic logic signed [POS_W-1:0] jitter(input logic signed [POS_W-1:0] base,
                                                     input int spread,
                                                     input logic [LEN_W-1:0] len);
    int off;
    int k;
    off = int'($urandom_range(0, 2 * spread)) - spread;
    k = int'($urandom_range(0, 2)) - 1;
    return POS_W'(int'(base) + off + k * int'(len));
  endfunction

  function automatic logic [LEN_W-1:0] pick_box();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return BOX_RESET;
      3:       return LEN_W'($urandom_range(1, 65536));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings (10 nm box, one slot): field extremes, the 4 nm^2 threshold
  // and both sides of the half-box wrap boundary
  task automatic test_single_slot_limits();
    gappy = 1'b0;
    send_beat(mk_beat(CMD_LOAD, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000));
    send_beat(mk_beat(CMD_LOAD, MAX_ENTRIES - 1, 8388607, -8388608, 8388607,
                      32'h80000000, 32'h7FFFFFFF));
    send_beat(mk_beat(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    // exactly 4 nm^2 is not too far, one step more is
    send_beat(mk_beat(CMD_QUERY, 0, 131072, 0, 0, 0, 0));
    send_beat(mk_beat(CMD_QUERY, MAX_ENTRIES - 1, 0, 0, 131073, -1, -1));
    // offset of exactly half the box stays put, just beyond it wraps
    send_beat(mk_beat(CMD_QUERY, 0, -327680, 0, 0, 0, 0));
    send_beat(mk_beat(CMD_QUERY, 0, 0, -327681, 0, 0, 0));
    send_beat(mk_beat(CMD_QUERY, 0, 327681, 327681, 327681, 0, 0));
    // far corner of the coordinate range, still too far after one wrap
    send_beat(mk_beat(CMD_QUERY, 0, 8388607, -8388608, -8388608, 0, 0));
  endtask

  // search start not beaten, equal distances, nothing to scan
  task automatic test_search_rules();
    gappy = 1'b0;
    // no wrap: slot 0 lies beyond the start, slot 1 sits exactly on it
    set_config('0, '0, '0, CFG_DATA_W'(2));
    send_beat(mk_beat(CMD_LOAD, 0, -8388608, -8388608, -8388608, 32'h12345678, 32'h9ABCDEF0));
    send_beat(mk_beat(CMD_LOAD, 1, 6553600, 6553600, 0, 5, 6));
    send_beat(mk_beat(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    // two slots at the same spot, the lower index keeps the lead
    set_config('0, '0, '0, CFG_DATA_W'(4));
    send_beat(mk_beat(CMD_LOAD, 2, 1000, 2000, 3000, 21, 22));
    send_beat(mk_beat(CMD_LOAD, 3, 1000, 2000, 3000, 31, 32));
    send_beat(mk_beat(CMD_QUERY, 0, 1000, 2000, 3000, 0, 0));
    // entry count of zero with the widest boxes
    set_config('1, '1, '1, CFG_DATA_W'(0));
    send_beat(mk_beat(CMD_QUERY, 0, 1000, 2000, 3000, 0, 0));
  endtask

  // a long run of loaded slots, then scans over all of them
  task automatic test_long_table();
    int j;
    set_config(LEN_W'($urandom_range(65536, 4 * 655360)),
               LEN_W'($urandom_range(65536, 4 * 655360)),
               LEN_W'($urandom_range(65536, 4 * 655360)), CFG_DATA_W'(LONG_SLOTS));
    gappy = 1'b1;
    for (int s = 0; s < LONG_SLOTS; s++) begin
      send_beat(mk_beat(CMD_LOAD, s, jitter('0, 1 << 21, '0), jitter('0, 1 << 21, '0),
                        jitter('0, 1 << 21, '0), $urandom, $urandom));
      pace_sender();
    end
    j = LONG_SLOTS - 1;
    send_beat(mk_beat(CMD_QUERY, 0, slot_x[j], slot_y[j], slot_z[j], 0, 0));
    send_beat(mk_beat(CMD_QUERY, 0, $urandom, $urandom, $urandom, 0, 0));
    j = $urandom_range(0, LONG_SLOTS - 1);
    send_beat(mk_beat(CMD_QUERY, 0, jitter(slot_x[j], 256, box_x),
                      jitter(slot_y[j], 256, box_y), jitter(slot_z[j], 256, box_z), 0, 0));
  endtask

  // phases of mixed loads and queries, most queries aimed near a stored point
  task automatic test_random_lookups();
    beat_t b;
    int    n;
    int    items;
    int    hole;
    int    j;
    int    spread;
    for (int phase = 0; phase < 8; phase++) begin
      // one phase over a long table, the rest short so scans stay quick
      if (phase == 5) begin
        items = 20;
        n = $urandom_range(200, LONG_SLOTS);
      end else begin
        items = 30;
        n = $urandom_range(1, 24);
      end
      set_config(pick_box(), pick_box(), pick_box(), CFG_DATA_W'(n));
      gappy = (phase % 3 != 2);
      for (int k = 0; k < items; k++) begin
        // never let a query reach a slot that has not been loaded
        hole = -1;
        for (int s = n - 1; s >= 0; s--)
          if (!slot_loaded[s]) hole = s;
        b.slot  = ADDR_W'($urandom);
        b.mean  = $urandom;
        b.gauss = $urandom;
        if (hole >= 0 || $urandom_range(0, 1) == 0) begin
          b.cmd = CMD_LOAD;
          if (hole >= 0) b.slot = ADDR_W'(hole);
          else if ($urandom_range(0, 9) != 0) b.slot = ADDR_W'($urandom_range(0, n - 1));
          if ($urandom_range(0, 3) == 0) begin
            b.x = POS_W'($urandom);
            b.y = POS_W'($urandom);
            b.z = POS_W'($urandom);
          end else begin
            b.x = jitter('0, 1 << 20, '0);
            b.y = jitter('0, 1 << 20, '0);
            b.z = jitter('0, 1 << 20, '0);
          end
        end else begin
          b.cmd = CMD_QUERY;
          if ($urandom_range(0, 4) == 0) begin
            b.x = POS_W'($urandom);
            b.y = POS_W'($urandom);
            b.z = POS_W'($urandom);
          end else begin
            j = $urandom_range(0, n - 1);
            case ($urandom_range(0, 3))
              0:       spread = 0;
              1:       spread = 255;
              2:       spread = 131072;
              default: spread = 262144;
            endcase
            b.x = jitter(slot_x[j], spread, box_x);
            b.y = jitter(slot_y[j], spread, box_y);
            b.z = jitter(slot_z[j], spread, box_z);
          end
        end
        send_beat(b);
        pace_sender();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_slot_limits();
    test_search_rules();
    test_long_table();
    test_random_lookups();
    wait_idle();
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pnpl_pkg.sv
sv/pnpl_cfg.sv
sv/pnpl_ctrl.sv
sv/pnpl_datapath.sv
sv/periodic_nearest_point_lookup_unit.sv
bench/tb_periodic_nearest_point_lookup_unit.sv
